// ===== rtl/ntsm_pkg.sv =====
`default_nettype none

package ntsm_pkg;

    // field widths
    localparam int ACTION_W = 32;
    localparam int ANGLE_W  = 32;
    localparam int LIFT_W   = 64;
    localparam int STEP_W   = 32;
    localparam int GAIN_W   = 32;

    // quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_W           = 31;
    localparam int TABLE_SPAN       = 4 * SINE_TABLE_DEPTH;
    localparam int SPAN_W           = $clog2(TABLE_SPAN + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIST_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_GAIN  = 1'b1;

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // truncating taylor series of sin, terms up to x^15, clamped to [0, 1.0]
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = '0;
            end
            if (sum > signed'(ONE_Q30))
            begin
                sum = signed'(ONE_Q30);
            end
            rom[k] = SINE_W'(sum);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ntsm_if.sv =====
`default_nettype none

interface ntsm_in_if;
    import ntsm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [ACTION_W-1:0] start_action;
    logic        [ANGLE_W-1:0]  start_angle;

    modport source (output valid, output opcode, output start_action, output start_angle,
                    input ready);
    modport sink   (input valid, input opcode, input start_action, input start_angle,
                    output ready);
endinterface

interface ntsm_out_if;
    import ntsm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ACTION_W-1:0] action;
    logic        [ANGLE_W-1:0]  angle;
    logic signed [LIFT_W-1:0]   lifted_angle;
    logic        [STEP_W-1:0]   step_index;

    modport source (output valid, output action, output angle, output lifted_angle,
                    output step_index, input ready);
    modport sink   (input valid, input action, input angle, input lifted_angle,
                    input step_index, output ready);
endinterface

interface ntsm_cfg_if;
    import ntsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/nontwist_standard_map_step_unit.sv =====
// Standard nontwist map iterator in fixed point.
// cmd: one word per item. opcode start loads action and angle, sets the lifted
//   angle to the angle and clears the step count; opcode step runs one map
//   iteration from the current state.
// res: one word per item with action, angle, lifted angle and step count
//   as they stand after that item.
// cfg: register writes (twist gain a, kick gain b), always ready; write only
//   while no item is in flight.
// An item is accepted only in the idle state, so the next item is not taken
//   until the last one has left the done state; all three products
//   share one 36x32 multiplier that a sequencer walks through table address,
//   sine lookup, kick, action update, square, width term, advance and state
//   update before done. A start item goes from idle straight to done.
// The result sits in an output register, so a new item is accepted while the
// previous word waits; if the receiver stalls, the following item finishes
// and holds in its last stage until the output register frees up.
// Reset clears state, gains and step count to zero and drops res.valid.
`default_nettype none

module nontwist_standard_map_step_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    ntsm_in_if.sink   cmd,
    ntsm_out_if.source res,
    ntsm_cfg_if.sink  cfg
);
    import ntsm_pkg::*;

    localparam int PM_W  = ANGLE_W + SPAN_W;
    localparam int MA_W  = 36;
    localparam int MB_W  = 32;
    localparam int MP_W  = MA_W + MB_W;
    localparam int JD_W  = ACTION_W + 2;
    localparam int D_W   = MP_W - 24;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    localparam logic signed [JD_W-1:0] ACT_MAX = JD_W'(64'sd2147483647);
    localparam logic signed [JD_W-1:0] ACT_MIN = -JD_W'(64'sd2147483648);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_ROM,
        S_KICK,
        S_ACT,
        S_SQ,
        S_WID,
        S_ADV,
        S_UPD,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [GAIN_W-1:0]   twist_reg, twist_next;
    logic signed [GAIN_W-1:0]   kick_reg, kick_next;
    logic signed [ACTION_W-1:0] action_reg, action_next;
    logic        [ANGLE_W-1:0]  angle_reg, angle_next;
    logic signed [LIFT_W-1:0]   lift_reg, lift_next;
    logic        [STEP_W-1:0]   step_reg, step_next;
    logic [SINE_IDX_W-1:0]      idx_reg, idx_next;
    logic                       neg_reg, neg_next;
    logic [SINE_W-1:0]          rom_reg;
    logic signed [MP_W-1:0]     prod_reg, prod_next;
    logic signed [MA_W-1:0]     w_reg, w_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [ACTION_W-1:0] out_action_reg, out_action_next;
    logic        [ANGLE_W-1:0]  out_angle_reg, out_angle_next;
    logic signed [LIFT_W-1:0]   out_lift_reg, out_lift_next;
    logic        [STEP_W-1:0]   out_step_reg, out_step_next;

    logic [PM_W-1:0]            pmul;
    logic [SPAN_W-1:0]          pidx;
    logic [1:0]                 quad;
    logic [SINE_IDX_W-1:0]      rem;
    logic signed [MB_W-1:0]     sine_val;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [MP_W-1:0]     mul_p;
    logic signed [JD_W-1:0]     jd;
    logic signed [63:0]         wdiff;
    logic signed [D_W-1:0]      dval;
    logic                       accept;
    logic                       out_free;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign res.valid        = out_valid_reg;
    assign res.action       = out_action_reg;
    assign res.angle        = out_angle_reg;
    assign res.lifted_angle = out_lift_reg;
    assign res.step_index   = out_step_reg;

    // table position: quadrant and index into the quarter wave
    always_comb
    begin
        pmul = PM_W'(angle_reg) * PM_W'(TABLE_SPAN);
        pidx = pmul[PM_W-1:ANGLE_W];
        if (pidx >= SPAN_W'(3 * SINE_TABLE_DEPTH))
        begin
            quad = 2'd3;
            rem  = SINE_IDX_W'(pidx - SPAN_W'(3 * SINE_TABLE_DEPTH));
        end
        else if (pidx >= SPAN_W'(2 * SINE_TABLE_DEPTH))
        begin
            quad = 2'd2;
            rem  = SINE_IDX_W'(pidx - SPAN_W'(2 * SINE_TABLE_DEPTH));
        end
        else if (pidx >= SPAN_W'(SINE_TABLE_DEPTH))
        begin
            quad = 2'd1;
            rem  = SINE_IDX_W'(pidx - SPAN_W'(SINE_TABLE_DEPTH));
        end
        else
        begin
            quad = 2'd0;
            rem  = SINE_IDX_W'(pidx);
        end
    end

    // shared multiplier
    always_comb
    begin
        sine_val = neg_reg ? -signed'(MB_W'(rom_reg)) : signed'(MB_W'(rom_reg));
        unique case (state_reg)
            S_KICK:
            begin
                mul_a = MA_W'(sine_val);
                mul_b = kick_reg;
            end
            S_SQ:
            begin
                mul_a = MA_W'(action_reg);
                mul_b = action_reg;
            end
            default:
            begin
                mul_a = w_reg;
                mul_b = twist_reg;
            end
        endcase
        mul_p = MP_W'(mul_a) * MP_W'(mul_b);
    end

    // kick, width term and angle advance taken from the product register
    always_comb
    begin
        jd    = JD_W'(action_reg) - signed'(prod_reg[63:30]);
        wdiff = (64'sd1 <<< 56) - signed'(prod_reg[63:0]);
        dval  = prod_reg[MP_W-1:24];
    end

    always_comb
    begin
        state_next      = state_reg;
        twist_next      = twist_reg;
        kick_next       = kick_reg;
        action_next     = action_reg;
        angle_next      = angle_reg;
        lift_next       = lift_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        w_next          = w_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_angle_next  = out_angle_reg;
        out_lift_next   = out_lift_reg;
        out_step_next   = out_step_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TWIST_GAIN: twist_next = signed'(cfg.data);
                CFG_KICK_GAIN:  kick_next  = signed'(cfg.data);
                default:        twist_next = twist_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_START)
                    begin
                        action_next = cmd.start_action;
                        angle_next  = cmd.start_angle;
                        lift_next   = signed'(LIFT_W'(cmd.start_angle));
                        step_next   = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_ADDR:
            begin
                idx_next   = quad[0] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - rem : rem;
                neg_next   = quad[1];
                state_next = S_ROM;
            end
            S_ROM:
            begin
                state_next = S_KICK;
            end
            S_KICK:
            begin
                prod_next  = mul_p;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (jd > ACT_MAX)
                begin
                    action_next = ACTION_W'(ACT_MAX);
                end
                else if (jd < ACT_MIN)
                begin
                    action_next = ACTION_W'(ACT_MIN);
                end
                else
                begin
                    action_next = ACTION_W'(jd);
                end
                state_next = S_SQ;
            end
            S_SQ:
            begin
                prod_next  = mul_p;
                state_next = S_WID;
            end
            S_WID:
            begin
                w_next     = wdiff[63:28];
                state_next = S_ADV;
            end
            S_ADV:
            begin
                prod_next  = mul_p;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                angle_next = angle_reg + ANGLE_W'(dval);
                lift_next  = lift_reg + LIFT_W'(dval);
                step_next  = step_reg + STEP_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = action_reg;
                    out_angle_next  = angle_reg;
                    out_lift_next   = lift_reg;
                    out_step_next   = step_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            twist_reg     <= '0;
            kick_reg      <= '0;
            action_reg    <= '0;
            angle_reg     <= '0;
            lift_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            twist_reg     <= twist_next;
            kick_reg      <= kick_next;
            action_reg    <= action_next;
            angle_reg     <= angle_next;
            lift_reg      <= lift_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        w_reg          <= w_next;
        out_action_reg <= out_action_next;
        out_angle_reg  <= out_angle_next;
        out_lift_reg   <= out_lift_next;
        out_step_reg   <= out_step_next;
    end

    // sine rom, registered read
    always_ff @(posedge clk)
    begin
        rom_reg <= SINE_ROM[idx_reg];
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == S_DONE))
        else $error("result word appeared outside the done stage");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("new word accepted while an item is in flight");

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |=> step_reg == $past(step_reg) + STEP_W'(1))
        else $error("step count did not advance on a map step");

endmodule

`default_nettype wire
